@@ design/ntcb_pkg.sv @@
// Shared constants, widths and types for the NTC Beta-equation temperature pipeline.
`timescale 1ns / 1ps
package ntcb_pkg;

  // Field and port widths
  localparam int SAMPLE_W    = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int TEMP_W      = 24;
  localparam int CONN_BIT    = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int OHMS_W      = 24;
  localparam int BETA_W      = 16;
  localparam int OFS_W       = 16;
  localparam int SCL_W       = 16;

  // Internal arithmetic widths
  localparam int EXP_W  = 6;   // exponent of a divider product (below 64)
  localparam int MANT_W = 31;  // normalized mantissa, Q1.30
  localparam int FRAC_W = 24;  // log2 fraction bits, one squaring round each
  localparam int LMAG_W = 31;  // |log2 ratio| in Q24
  localparam int K_W    = 28;
  localparam int T_W    = 39;
  localparam int D_W    = 42;
  localparam int DMAG_W = 41;
  localparam int NUMB_W = 31;
  localparam int DEN_W  = 48;
  localparam int NUM_W  = 64;
  localparam int Q_W    = 41;  // quotient bits kept; larger results saturate anyway
  localparam int TK_W   = 42;
  localparam int V_W    = 44;
  localparam int VMAG_W = 41;
  localparam int PROD_W = 57;
  localparam int RND_W  = 46;

  // T0 * ln2 in Q20, T0 = 298.15 K
  localparam logic [K_W-1:0]  K_Q20     = 28'd216700637;
  localparam logic [14:0]     T0_X100   = 15'd29815;
  localparam logic [V_W-1:0]  ZERO_C_Q8 = 44'd69926;
  localparam logic [V_W-1:0]  CLAMP_V   = 44'h100_0000_0000;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 24'h7F_FFFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 24'h80_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_SIDE = 3'd0,
    REG_REF_OHMS  = 3'd1,
    REG_NOM_OHMS  = 3'd2,
    REG_BETA      = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_SCALE     = 3'd5
  } cfg_reg_t;

endpackage

@@ design/ntc_beta_temperature.sv @@
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline,
// while the first stage still takes a beat whenever it is empty.
// Work: 24 squaring rounds per log2 (one multiplier a stage, two logs side by
// side) and a 41-stage restoring divider set the depth.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the
// register defaults.
`timescale 1ns / 1ps
module ntc_beta_temperature #(
  parameter int ADC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [11:0] adc_sample
  input  logic [ntcb_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [23:0] temperature, [24] connected
  output logic [ntcb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [ntcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntcb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ntcb_pkg::*;

  localparam int PW     = OHMS_W + ADC_BITS;
  localparam int FS_INT = 2**ADC_BITS - 1;
  localparam logic [ADC_BITS-1:0] FS     = ADC_BITS'(FS_INT);
  localparam logic [ADC_BITS-1:0] BAND   = ADC_BITS'(FS_INT / 20);
  localparam logic [ADC_BITS-1:0] HI_LIM = ADC_BITS'(FS_INT - FS_INT / 20);

  typedef struct packed {
    logic                conn;
    logic [MANT_W-1:0]   m_n;
    logic [MANT_W-1:0]   m_d;
    logic [EXP_W-1:0]    e_n;
    logic [EXP_W-1:0]    e_d;
    logic [FRAC_W-1:0]   f_n;
    logic [FRAC_W-1:0]   f_d;
  } log_stage_t;

  typedef struct packed {
    logic                conn;
    logic                dpos;
    logic                ovf;
    logic [DEN_W-1:0]    den;
    logic [DEN_W-1:0]    rem;
    logic [Q_W-1:0]      nlo;
    logic [Q_W-1:0]      q;
  } div_stage_t;

  // Configuration registers
  logic                  high_side_r;
  logic [OHMS_W-1:0]     ref_ohms_r;
  logic [OHMS_W-1:0]     nom_ohms_r;
  logic [BETA_W-1:0]     beta_r;
  logic [OFS_W-1:0]      offset_r;
  logic [SCL_W-1:0]      scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_side_r <= 1'b0;
      ref_ohms_r  <= 24'd10000;
      nom_ohms_r  <= 24'd10000;
      beta_r      <= 16'd3950;
      offset_r    <= 16'd0;
      scale_r     <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HIGH_SIDE: high_side_r <= cfg_data[0];
        REG_REF_OHMS:  ref_ohms_r  <= cfg_data[OHMS_W-1:0];
        REG_NOM_OHMS:  nom_ohms_r  <= cfg_data[OHMS_W-1:0];
        REG_BETA:      beta_r      <= cfg_data[BETA_W-1:0];
        REG_OFFSET:    offset_r    <= cfg_data[OFS_W-1:0];
        REG_SCALE:     scale_r     <= cfg_data[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [OHMS_W-1:0] rr_eff, rn_eff;
  logic [BETA_W-1:0] b_eff;
  assign rr_eff = (ref_ohms_r == '0) ? OHMS_W'(1) : ref_ohms_r;
  assign rn_eff = (nom_ohms_r == '0) ? OHMS_W'(1) : nom_ohms_r;
  assign b_eff  = (beta_r == '0) ? BETA_W'(1) : beta_r;

  // Global advance: everything moves unless the output beat is held
  logic adv, s1_en;
  logic out_tvalid_r;
  logic s1_v_r;
  assign adv       = !out_tvalid_r || out_tready;
  assign s1_en     = adv || !s1_v_r;
  assign in_tready = s1_en;

  function automatic logic [EXP_W-1:0] top_bit(input logic [PW-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 0; i < PW; i++) begin
      if (x[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

  function automatic logic [MANT_W-1:0] normalize(input logic [PW-1:0] x,
                                                  input logic [EXP_W-1:0] e);
    logic [PW+MANT_W-2:0] wide;
    wide = {x, {(MANT_W-1){1'b0}}} >> e;
    return wide[MANT_W-1:0];
  endfunction

  // One squaring round: returns {fraction bit, next mantissa}
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
    if (sq[2*MANT_W-1]) return {1'b1, sq[2*MANT_W-1:MANT_W]};
    else                return {1'b0, sq[2*MANT_W-2:MANT_W-1]};
  endfunction

  // ---- Stage 1: band check and divider products
  logic [ADC_BITS-1:0] samp, n_val, d_val;
  logic                inband;
  logic                s1_conn_r;
  logic [PW-1:0]       s1_xn_r, s1_xd_r;

  always_comb begin
    samp   = ADC_BITS'(in_tdata[SAMPLE_W-1:0]);
    inband = (samp > BAND) && (samp < HI_LIM);
    n_val  = high_side_r ? (FS - samp) : samp;
    d_val  = high_side_r ? samp : (FS - samp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_en) s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_conn_r <= inband;
      s1_xn_r   <= PW'(rr_eff) * PW'(n_val);
      s1_xd_r   <= PW'(d_val) * PW'(rn_eff);
    end
  end

  // ---- Stage 2: leading-one position
  logic                s2_v_r, s2_conn_r;
  logic [PW-1:0]       s2_xn_r, s2_xd_r;
  logic [EXP_W-1:0]    s2_en_r, s2_ed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_conn_r <= s1_conn_r;
      s2_xn_r   <= s1_xn_r;
      s2_xd_r   <= s1_xd_r;
      s2_en_r   <= top_bit(s1_xn_r);
      s2_ed_r   <= top_bit(s1_xd_r);
    end
  end

  // ---- Stage 3 and 24 squaring rounds: lg_r[0] holds the normalized mantissas
  logic       lg_v_r [0:FRAC_W];
  log_stage_t lg_r   [0:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) lg_v_r[0] <= 1'b0;
    else if (adv) lg_v_r[0] <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_r[0].conn <= s2_conn_r;
      lg_r[0].m_n  <= normalize(s2_xn_r, s2_en_r);
      lg_r[0].m_d  <= normalize(s2_xd_r, s2_ed_r);
      lg_r[0].e_n  <= s2_en_r;
      lg_r[0].e_d  <= s2_ed_r;
      lg_r[0].f_n  <= '0;
      lg_r[0].f_d  <= '0;
    end
  end

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_log
    logic [MANT_W:0] step_n, step_d;
    assign step_n = sq_step(lg_r[k-1].m_n);
    assign step_d = sq_step(lg_r[k-1].m_d);

    always_ff @(posedge clk) begin
      if (!rst_n) lg_v_r[k] <= 1'b0;
      else if (adv) lg_v_r[k] <= lg_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lg_r[k].conn <= lg_r[k-1].conn;
        lg_r[k].e_n  <= lg_r[k-1].e_n;
        lg_r[k].e_d  <= lg_r[k-1].e_d;
        lg_r[k].m_n  <= step_n[MANT_W-1:0];
        lg_r[k].m_d  <= step_d[MANT_W-1:0];
        lg_r[k].f_n  <= {lg_r[k-1].f_n[FRAC_W-2:0], step_n[MANT_W]};
        lg_r[k].f_d  <= {lg_r[k-1].f_d[FRAC_W-2:0], step_d[MANT_W]};
      end
    end
  end

  // ---- Log ratio in Q24, sign and magnitude
  logic signed [EXP_W+FRAC_W+1:0] l_diff;
  logic                sl_v_r, sl_conn_r, sl_neg_r;
  logic [LMAG_W-1:0]   sl_mag_r;

  assign l_diff = $signed({2'b00, lg_r[FRAC_W].e_n, lg_r[FRAC_W].f_n})
                - $signed({2'b00, lg_r[FRAC_W].e_d, lg_r[FRAC_W].f_d});

  always_ff @(posedge clk) begin
    if (!rst_n) sl_v_r <= 1'b0;
    else if (adv) sl_v_r <= lg_v_r[FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_conn_r <= lg_r[FRAC_W].conn;
      sl_neg_r  <= l_diff[EXP_W+FRAC_W+1];
      sl_mag_r  <= l_diff[EXP_W+FRAC_W+1] ? LMAG_W'(-l_diff) : LMAG_W'(l_diff);
    end
  end

  // ---- Scale by T0*ln2
  logic [LMAG_W+K_W-1:0] k_prod;
  logic                sk_v_r, sk_conn_r, sk_neg_r;
  logic [T_W-1:0]      sk_t_r;

  assign k_prod = (LMAG_W+K_W)'(sl_mag_r) * (LMAG_W+K_W)'(K_Q20);

  always_ff @(posedge clk) begin
    if (!rst_n) sk_v_r <= 1'b0;
    else if (adv) sk_v_r <= sl_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sk_conn_r <= sl_conn_r;
      sk_neg_r  <= sl_neg_r;
      sk_t_r    <= k_prod[LMAG_W+K_W-1:20];
    end
  end

  // ---- Denominator D = beta*2^24 + term, numerator base 100*T0*beta
  logic signed [D_W-1:0] d_term, d_val_s;
  logic                sd_v_r, sd_conn_r, sd_dpos_r;
  logic [DMAG_W-1:0]   sd_dmag_r;
  logic [NUMB_W-1:0]   sd_numb_r;

  always_comb begin
    d_term  = $signed({3'b000, sk_t_r});
    d_val_s = $signed({2'b00, b_eff, 24'd0}) + (sk_neg_r ? -d_term : d_term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sd_v_r <= 1'b0;
    else if (adv) sd_v_r <= sk_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_conn_r <= sk_conn_r;
      sd_dpos_r <= !d_val_s[D_W-1] && (d_val_s != '0);
      sd_dmag_r <= d_val_s[DMAG_W-1:0];
      sd_numb_r <= NUMB_W'(T0_X100) * NUMB_W'(b_eff);
    end
  end

  // ---- den = 100*D
  logic                sn_v_r, sn_conn_r, sn_dpos_r;
  logic [DEN_W-1:0]    sn_den_r;
  logic [NUMB_W-1:0]   sn_numb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sn_v_r <= 1'b0;
    else if (adv) sn_v_r <= sd_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_conn_r <= sd_conn_r;
      sn_dpos_r <= sd_dpos_r;
      sn_den_r  <= DEN_W'(sd_dmag_r) * DEN_W'(7'd100);
      sn_numb_r <= sd_numb_r;
    end
  end

  // ---- Rounded dividend N = num + den/2
  logic                sr_v_r, sr_conn_r, sr_dpos_r;
  logic [DEN_W-1:0]    sr_den_r;
  logic [NUM_W-1:0]    sr_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sr_v_r <= 1'b0;
    else if (adv) sr_v_r <= sn_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_conn_r <= sn_conn_r;
      sr_dpos_r <= sn_dpos_r;
      sr_den_r  <= sn_den_r;
      sr_num_r  <= {1'b0, sn_numb_r, 32'd0} + NUM_W'(sn_den_r >> 1);
    end
  end

  // ---- Divider: dv_r[0] holds the overflow check and the initial remainder
  logic       dv_v_r [0:Q_W];
  div_stage_t dv_r   [0:Q_W];
  logic [DEN_W-1:0] n_hi;

  assign n_hi = DEN_W'(sr_num_r[NUM_W-1:Q_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= sr_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].conn <= sr_conn_r;
      dv_r[0].dpos <= sr_dpos_r;
      dv_r[0].ovf  <= (n_hi >= sr_den_r);
      dv_r[0].den  <= sr_den_r;
      dv_r[0].rem  <= n_hi;
      dv_r[0].nlo  <= sr_num_r[Q_W-1:0];
      dv_r[0].q    <= '0;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [DEN_W:0] trial;
    logic           fits;
    assign trial = {dv_r[j-1].rem, dv_r[j-1].nlo[Q_W-1]};
    assign fits  = trial >= {1'b0, dv_r[j-1].den};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (adv) dv_v_r[j] <= dv_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j].conn <= dv_r[j-1].conn;
        dv_r[j].dpos <= dv_r[j-1].dpos;
        dv_r[j].ovf  <= dv_r[j-1].ovf;
        dv_r[j].den  <= dv_r[j-1].den;
        dv_r[j].rem  <= fits ? DEN_W'(trial - {1'b0, dv_r[j-1].den})
                             : trial[DEN_W-1:0];
        dv_r[j].nlo  <= {dv_r[j-1].nlo[Q_W-2:0], 1'b0};
        dv_r[j].q    <= {dv_r[j-1].q[Q_W-2:0], fits};
      end
    end
  end

  // ---- Celsius, offset, clamp
  logic [TK_W-1:0]       tk;
  logic signed [V_W-1:0] v_raw, v_clip;
  logic                  sv_v_r, sv_conn_r, sv_dpos_r, sv_neg_r;
  logic [VMAG_W-1:0]     sv_mag_r;

  always_comb begin
    tk    = dv_r[Q_W].ovf ? {1'b1, {(TK_W-1){1'b0}}} : {1'b0, dv_r[Q_W].q};
    v_raw = $signed({2'b00, tk}) - $signed(ZERO_C_Q8)
          - $signed({{(V_W-OFS_W){offset_r[OFS_W-1]}}, offset_r});
    if (v_raw > $signed(CLAMP_V))       v_clip = $signed(CLAMP_V);
    else if (v_raw < -$signed(CLAMP_V)) v_clip = -$signed(CLAMP_V);
    else                                v_clip = v_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_v_r <= 1'b0;
    else if (adv) sv_v_r <= dv_v_r[Q_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_conn_r <= dv_r[Q_W].conn;
      sv_dpos_r <= dv_r[Q_W].dpos;
      sv_neg_r  <= v_clip[V_W-1];
      sv_mag_r  <= v_clip[V_W-1] ? VMAG_W'(-v_clip) : VMAG_W'(v_clip);
    end
  end

  // ---- Scale multiply
  logic                ss_v_r, ss_conn_r, ss_dpos_r, ss_neg_r;
  logic [PROD_W-1:0]   ss_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ss_v_r <= 1'b0;
    else if (adv) ss_v_r <= sv_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_conn_r <= sv_conn_r;
      ss_dpos_r <= sv_dpos_r;
      ss_neg_r  <= sv_neg_r;
      ss_prod_r <= PROD_W'(sv_mag_r) * PROD_W'(scale_r);
    end
  end

  // ---- Round, saturate, output register
  logic [PROD_W:0]     rnd_sum;
  logic [RND_W-1:0]    rnd;
  logic [TEMP_W-1:0]   sat_temp, temp_nxt;
  logic [TEMP_W-1:0]   out_temp_r;
  logic                out_conn_r;

  always_comb begin
    rnd_sum = (PROD_W+1)'(ss_prod_r) + (PROD_W+1)'(2048);
    rnd     = rnd_sum[PROD_W:12];
    if (ss_neg_r) begin
      if (rnd >= RND_W'(24'h80_0000)) sat_temp = TEMP_MIN;
      else                           sat_temp = ~rnd[TEMP_W-1:0] + TEMP_W'(1);
    end else begin
      if (rnd > RND_W'(TEMP_MAX)) sat_temp = TEMP_MAX;
      else                        sat_temp = rnd[TEMP_W-1:0];
    end
    if (!ss_conn_r)      temp_nxt = '0;
    else if (!ss_dpos_r) temp_nxt = TEMP_MAX;
    else                 temp_nxt = sat_temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (adv) out_tvalid_r <= ss_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp_r <= temp_nxt;
      out_conn_r <= ss_conn_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-TEMP_W-1){1'b0}}, out_conn_r, out_temp_r};

endmodule

@@ design/ntcb_checker.sv @@
// Port-level checks for the NTC temperature block, bound to the top level.
`timescale 1ns / 1ps
module ntcb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ntcb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ntcb_pkg::*;

  // No output beat right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A disconnected sample reads as zero temperature
  a_disconnect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[CONN_BIT] |-> out_tdata[TEMP_W-1:0] == '0)
    else $error("nonzero temperature on disconnected beat");

  // Hold a stalled beat
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind ntc_beta_temperature ntcb_checker u_ntcb_checker (.*);
